@@ sv/cnas_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Crank-Nicolson advection solver.
// No dependencies; every other file imports this package.
package cnas_pkg;

    localparam int NODES_DEFAULT = 64;
    localparam int SAMPLE_W      = 16;
    localparam int RHS_W         = 18;
    localparam int PROD_W        = 36;
    localparam int RND_W         = 22;
    localparam int DEN_W         = 20;
    localparam int NUM_W         = 21;
    localparam int STEP_W        = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int COEF_FRAC     = 14;

    localparam logic [CFG_IDX_W-1:0] REG_EXPLICIT_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMPLICIT_COEF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_RIGHT = 3'd4;

    localparam logic signed [SAMPLE_W-1:0] EXPLICIT_RESET = 16'sd406;
    localparam logic signed [SAMPLE_W-1:0] IMPLICIT_RESET = 16'sd406;
    localparam logic [STEP_W-1:0]          STEPS_RESET    = 10'd100;
    localparam logic signed [SAMPLE_W-1:0] BOUND_RESET    = 16'sd4096;

    localparam logic signed [DEN_W-1:0] COEF_ONE = 20'sd16384;

    typedef enum logic [4:0] {
        S_LOAD, S_STEP_CHK,
        S_F_RDL, S_F_RDC, S_F_RDR, S_F_CAPR, S_F_MUL, S_F_D, S_F_DEN, S_F_NUM,
        S_F_DIVC, S_F_WC, S_F_DIVD, S_F_WD,
        S_B_RD0, S_B_LD, S_B_WT, S_B_MUL, S_B_X,
        S_BL, S_BR,
        S_E_RD, S_E_LD, S_E_W
    } state_t;

    typedef enum logic [1:0] {RD_PREV, RD_CUR, RD_NEXT} rd_sel_t;
    typedef enum logic [1:0] {MUL_DIFF, MUL_MCP, MUL_MDP, MUL_CPX} mul_sel_t;

    typedef struct packed {
        logic     load_wr;
        logic     set_n;
        logic     idx_clr;
        logic     idx_inc;
        logic     idx_dec;
        logic     step_clr;
        logic     step_inc;
        logic     sweep_clr;
        rd_sel_t  rd_sel;
        logic     cap_l;
        logic     cap_c;
        logic     cap_r;
        mul_sel_t mul_sel;
        logic     d_en;
        logic     den_en;
        logic     num_en;
        logic     div_start;
        logic     div_dp;
        logic     cp_en;
        logic     dp_en;
        logic     xl_en;
        logic     xc_en;
        logic     bl_wr;
        logic     br_wr;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic idx_zero;
        logic idx_end;
        logic idx_full;
        logic steps_done;
        logic div_done;
        logic out_taken;
    } sts_t;

    // round half up to Q.14 drop: floor((p + 2^13) / 2^14)
    function automatic logic signed [RND_W-1:0] rnd_q14(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] s;
        s = (PROD_W+1)'(p) + 37'sd8192;
        return s[COEF_FRAC+RND_W-1:COEF_FRAC];
    endfunction

    function automatic logic signed [RHS_W-1:0] sat_rhs(input logic signed [23:0] v);
        if (v > 24'sd131071)
            return 18'sd131071;
        else if (v < -24'sd131072)
            return -18'sd131072;
        else
            return v[RHS_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [23:0] v);
        if (v > 24'sd32767)
            return 16'sd32767;
        else if (v < -24'sd32768)
            return -16'sd32768;
        else
            return v[SAMPLE_W-1:0];
    endfunction

endpackage

@@ sv/crank_nicolson_advection_solver.sv @@
// Top level of the Crank-Nicolson advection solver: controller plus datapath.
// Depends on cnas_pkg, cnas_ctrl and cnas_dp.
//
//   channel   dir   bits                        handshake
//   s_        in    tdata[15:0] sample, tlast   tvalid/tready
//   m_        out   tdata[15:0] sample, tlast   tvalid/tready
//   cfg_      in    index[2:0], wdata[15:0]     wr_en only
//
// Load accepts one word per cycle. Each time step runs a forward sweep over the nodes,
// in which two bit-serial divisions per node dominate, then the back substitution pass,
// the boundary writes and the step check. Emit waits on m_tready for each word; s_tready is
// low from end of load until the last result is taken. Reset returns control state,
// counters and config registers to defaults, not memories or datapath registers.
module crank_nicolson_advection_solver
    import cnas_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_in
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // [15:0] sample_out
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    cnas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cnas_dp #(
        .NODES (NODES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample_in (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ sv/cnas_div.sv @@
// Bit-serial rounded divider: num * 2^14 / den, ties away from zero, saturated to 18 bits.
// Depends on cnas_pkg.
module cnas_div
    import cnas_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [RHS_W-1:0] quot
);

    localparam int DIVD_W = 36;
    localparam int CNT_W  = 6;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DIVD_W-1:0]       quo_reg, quo_next;
    logic [DEN_W-1:0]        ad_reg, ad_next;
    logic                    neg_reg, neg_next;
    logic signed [RHS_W-1:0] q_reg, q_next;

    logic [NUM_W-1:0]  an;
    logic [DEN_W-1:0]  ad;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [DIVD_W-1:0] quo_step;

    assign an       = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign ad       = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign trial    = {rem_reg, quo_reg[DIVD_W-1]};
    assign ge       = trial >= {1'b0, ad_reg};
    assign quo_step = {quo_reg[DIVD_W-2:0], ge};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ad_next   = ad_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        if (start) begin
            if (den == '0) begin
                done_next = 1'b1;
                if (num > 0)
                    q_next = 18'sd131071;
                else if (num < 0)
                    q_next = -18'sd131072;
                else
                    q_next = '0;
            end else begin
                busy_next = 1'b1;
                cnt_next  = CNT_W'(DIVD_W);
                rem_next  = '0;
                quo_next  = {1'b0, an, 14'd0} + DIVD_W'(ad[DEN_W-1:1]);
                ad_next   = ad;
                neg_next  = num[NUM_W-1] != den[DEN_W-1];
            end
        end else if (busy_reg) begin
            rem_next = ge ? DEN_W'(trial - {1'b0, ad_reg}) : trial[DEN_W-1:0];
            quo_next = quo_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                    q_next = (quo_step > DIVD_W'(131072)) ? -18'sd131072
                                                          : RHS_W'(-quo_step);
                else
                    q_next = (quo_step > DIVD_W'(131071)) ? 18'sd131071
                                                          : RHS_W'(quo_step);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ad_reg  <= ad_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

@@ sv/cnas_ctrl.sv @@
// Sequencer for load, forward sweep, back substitution, boundary forcing and emit.
// Depends on cnas_pkg.
module cnas_ctrl
    import cnas_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tlast,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CUR;
        cmd.mul_sel = MUL_DIFF;
        s_tready   = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_wr = 1'b1;
                    if (s_tlast || sts.idx_full) begin
                        cmd.set_n    = 1'b1;
                        cmd.step_clr = 1'b1;
                        state_next   = S_STEP_CHK;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_STEP_CHK: begin
                cmd.idx_clr = 1'b1;
                if (sts.steps_done) begin
                    state_next = S_E_RD;
                end else begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_F_RDL;
                end
            end
            S_F_RDL: begin
                cmd.rd_sel = RD_PREV;
                state_next = S_F_RDC;
            end
            S_F_RDC: begin
                cmd.cap_l  = 1'b1;
                state_next = S_F_RDR;
            end
            S_F_RDR: begin
                cmd.cap_c  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = S_F_CAPR;
            end
            S_F_CAPR: begin
                cmd.cap_r  = 1'b1;
                state_next = S_F_MUL;
            end
            S_F_MUL: begin
                cmd.mul_sel = MUL_DIFF;
                state_next  = S_F_D;
            end
            S_F_D: begin
                cmd.d_en    = 1'b1;
                cmd.mul_sel = MUL_MCP;
                state_next  = S_F_DEN;
            end
            S_F_DEN: begin
                cmd.den_en  = 1'b1;
                cmd.mul_sel = MUL_MDP;
                state_next  = S_F_NUM;
            end
            S_F_NUM: begin
                cmd.num_en = 1'b1;
                state_next = S_F_DIVC;
            end
            S_F_DIVC: begin
                cmd.div_start = 1'b1;
                state_next    = S_F_WC;
            end
            S_F_WC: begin
                if (sts.div_done) begin
                    cmd.cp_en  = 1'b1;
                    state_next = S_F_DIVD;
                end
            end
            S_F_DIVD: begin
                cmd.div_start = 1'b1;
                cmd.div_dp    = 1'b1;
                state_next    = S_F_WD;
            end
            S_F_WD: begin
                if (sts.div_done) begin
                    cmd.dp_en = 1'b1;
                    if (sts.idx_end) begin
                        state_next = S_B_RD0;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_F_RDL;
                    end
                end
            end
            S_B_RD0: begin
                state_next = S_B_LD;
            end
            S_B_LD: begin
                cmd.xl_en = 1'b1;
                if (sts.idx_zero) begin
                    state_next = S_BL;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_B_WT;
                end
            end
            S_B_WT: begin
                state_next = S_B_MUL;
            end
            S_B_MUL: begin
                cmd.mul_sel = MUL_CPX;
                state_next  = S_B_X;
            end
            S_B_X: begin
                cmd.xc_en = 1'b1;
                if (sts.idx_zero) begin
                    state_next = S_BL;
                end else begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_B_WT;
                end
            end
            S_BL: begin
                cmd.bl_wr  = 1'b1;
                state_next = S_BR;
            end
            S_BR: begin
                cmd.br_wr    = 1'b1;
                cmd.step_inc = 1'b1;
                state_next   = S_STEP_CHK;
            end
            S_E_RD: begin
                state_next = S_E_LD;
            end
            S_E_LD: begin
                cmd.out_load = 1'b1;
                state_next   = S_E_W;
            end
            S_E_W: begin
                if (sts.out_taken) begin
                    if (sts.idx_end) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_LOAD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_E_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

@@ sv/cnas_dp.sv @@
// Datapath: grid and sweep memories, shared multiplier, divider, counters and output register.
// Depends on cnas_pkg and cnas_div.
module cnas_dp
    import cnas_pkg::*;
#(
    parameter int NODES = NODES_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic [SAMPLE_W-1:0]       m_tdata,
    output logic                      m_tlast
);

    localparam int AW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);

    logic signed [SAMPLE_W-1:0] e_reg, m_reg, bl_reg, br_reg;
    logic [STEP_W-1:0]          steps_reg;

    logic [AW-1:0]     idx_reg;
    logic [CW-1:0]     n_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     nm1_full;
    logic [AW-1:0]     nm1;

    logic signed [SAMPLE_W-1:0] grid_mem [NODES];
    logic signed [RHS_W-1:0]    ratio_mem [NODES];
    logic signed [RHS_W-1:0]    rhs_mem [NODES];
    logic signed [SAMPLE_W-1:0] grid_rd_reg;
    logic signed [RHS_W-1:0]    ratio_rd_reg, rhs_rd_reg;

    logic signed [SAMPLE_W-1:0] ul_reg, uc_reg, ur_reg, x_reg;
    logic signed [RHS_W-1:0]    d_reg, cp_reg, dp_reg;
    logic signed [DEN_W-1:0]    den_reg;
    logic signed [NUM_W-1:0]    num_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [RND_W-1:0]    prod_rnd;

    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_last_reg;

    logic [AW-1:0]              grid_raddr, grid_waddr;
    logic                       grid_we;
    logic signed [SAMPLE_W-1:0] grid_wdata, x_new;
    logic signed [RHS_W-1:0]    mul_a, mul_b;
    logic signed [NUM_W-1:0]    div_num;
    logic                       div_done;
    logic signed [RHS_W-1:0]    div_q;

    assign nm1_full = n_reg - CW'(1);
    assign nm1      = nm1_full[AW-1:0];
    assign prod_rnd = rnd_q14(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg     <= EXPLICIT_RESET;
            m_reg     <= IMPLICIT_RESET;
            steps_reg <= STEPS_RESET;
            bl_reg    <= BOUND_RESET;
            br_reg    <= BOUND_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_EXPLICIT_COEF:  e_reg     <= cfg_wdata;
                REG_IMPLICIT_COEF:  m_reg     <= cfg_wdata;
                REG_STEP_COUNT:     steps_reg <= cfg_wdata[STEP_W-1:0];
                REG_BOUNDARY_LEFT:  bl_reg    <= cfg_wdata;
                REG_BOUNDARY_RIGHT: br_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            n_reg    <= '0;
            step_reg <= '0;
        end else begin
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            else if (cmd.idx_dec)
                idx_reg <= idx_reg - 1'b1;
            if (cmd.set_n)
                n_reg <= CW'(idx_reg) + CW'(1);
            if (cmd.step_clr)
                step_reg <= '0;
            else if (cmd.step_inc)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_comb begin
        case (cmd.rd_sel)
            RD_PREV: grid_raddr = idx_reg - 1'b1;
            RD_NEXT: grid_raddr = idx_reg + 1'b1;
            default: grid_raddr = idx_reg;
        endcase
    end

    always_comb begin
        if (cmd.xl_en)
            x_new = sat_sample(24'(rhs_rd_reg));
        else
            x_new = sat_sample(24'(rhs_rd_reg) - 24'(prod_rnd));
    end

    assign grid_we    = cmd.load_wr | cmd.xl_en | cmd.xc_en | cmd.bl_wr | cmd.br_wr;
    assign grid_waddr = cmd.bl_wr ? '0 : (cmd.br_wr ? nm1 : idx_reg);

    always_comb begin
        if (cmd.load_wr)
            grid_wdata = sample_in;
        else if (cmd.bl_wr)
            grid_wdata = bl_reg;
        else if (cmd.br_wr)
            grid_wdata = br_reg;
        else
            grid_wdata = x_new;
    end

    always_ff @(posedge aclk) begin
        if (grid_we)
            grid_mem[grid_waddr] <= grid_wdata;
        grid_rd_reg <= grid_mem[grid_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.dp_en) begin
            ratio_mem[idx_reg] <= cp_reg;
            rhs_mem[idx_reg]   <= div_q;
        end
        ratio_rd_reg <= ratio_mem[idx_reg];
        rhs_rd_reg   <= rhs_mem[idx_reg];
    end

    always_comb begin
        case (cmd.mul_sel)
            MUL_DIFF: begin
                mul_a = RHS_W'(e_reg);
                mul_b = RHS_W'(ur_reg) - RHS_W'(ul_reg);
            end
            MUL_MCP: begin
                mul_a = RHS_W'(m_reg);
                mul_b = cp_reg;
            end
            MUL_MDP: begin
                mul_a = RHS_W'(m_reg);
                mul_b = dp_reg;
            end
            default: begin
                mul_a = ratio_rd_reg;
                mul_b = RHS_W'(x_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.cap_l)
            ul_reg <= (idx_reg == '0) ? '0 : grid_rd_reg;
        if (cmd.cap_c)
            uc_reg <= grid_rd_reg;
        if (cmd.cap_r)
            ur_reg <= (idx_reg == nm1) ? '0 : grid_rd_reg;
        if (cmd.d_en)
            d_reg <= sat_rhs(24'(uc_reg) + 24'(prod_rnd));
        if (cmd.den_en)
            den_reg <= DEN_W'(24'(COEF_ONE) - 24'(prod_rnd));
        if (cmd.num_en)
            num_reg <= NUM_W'(24'(d_reg) - 24'(prod_rnd));
        if (cmd.sweep_clr) begin
            cp_reg <= '0;
            dp_reg <= '0;
        end else begin
            if (cmd.cp_en)
                cp_reg <= div_q;
            if (cmd.dp_en)
                dp_reg <= div_q;
        end
        if (cmd.xl_en || cmd.xc_en)
            x_reg <= x_new;
    end

    assign div_num = cmd.div_dp ? num_reg : -NUM_W'(m_reg);

    cnas_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= grid_rd_reg;
            out_last_reg <= idx_reg == nm1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign sts.idx_zero   = idx_reg == '0;
    assign sts.idx_end    = idx_reg == nm1;
    assign sts.idx_full   = idx_reg == AW'(NODES - 1);
    assign sts.steps_done = step_reg == steps_reg;
    assign sts.div_done   = div_done;
    assign sts.out_taken  = out_valid_reg & m_tready;

endmodule

@@ test/tb_crank_nicolson_advection_solver.sv @@
// Self-checking testbench for crank_nicolson_advection_solver: loads grids of Q4.12 words,
// predicts the solved grid with a fixed-point Crank-Nicolson model and checks every word.
// Depends on cnas_pkg and the solver RTL.
module tb_crank_nicolson_advection_solver
    import cnas_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    class cn_scoreboard;
        logic signed [15:0] explicit_c, implicit_c, bound_l, bound_r;
        logic [9:0]         steps;
        longint             grid[64];
        longint             ratio[64];
        longint             rhs[64];
        int unsigned        loaded;
        int                 errors;
        logic [15:0]        solved_q[$];
        bit                 last_q[$];

        function new();
            explicit_c = 16'sd406;
            implicit_c = 16'sd406;
            steps      = 10'd100;
            bound_l    = 16'sd4096;
            bound_r    = 16'sd4096;
            loaded     = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_EXPLICIT_COEF:  explicit_c = val;
                REG_IMPLICIT_COEF:  implicit_c = val;
                REG_STEP_COUNT:     steps = val[9:0];
                REG_BOUNDARY_LEFT:  bound_l = val;
                REG_BOUNDARY_RIGHT: bound_r = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint v, int bits);
            longint hi, lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint rnd14(longint v);
            return (v + 8192) >>> 14;
        endfunction

        function longint quot(longint num, longint den);
            longint an, ad, q;
            bit     neg;
            if (den == 0)
                return num > 0 ? 131071 : (num < 0 ? -131072 : 0);
            neg = (num < 0) != (den < 0);
            an  = (num < 0 ? -num : num) * 16384;
            ad  = den < 0 ? -den : den;
            q   = (an + ad / 2) / ad;
            return clip(neg ? -q : q, 18);
        endfunction

        function void time_step(int n);
            longint e, m, cp_prev, dp_prev, u, ul, ur, d, den, x;
            e = longint'(explicit_c);
            m = longint'(implicit_c);
            cp_prev = 0;
            dp_prev = 0;
            for (int i = 0; i < n; i++) begin
                u  = grid[i];
                ul = (i > 0) ? grid[i-1] : 0;
                ur = (i + 1 < n) ? grid[i+1] : 0;
                d  = clip(u + rnd14(e * (ur - ul)), 18);
                den = 16384 - rnd14(m * cp_prev);
                ratio[i] = quot(-m, den);
                rhs[i]   = quot(d - rnd14(m * dp_prev), den);
                cp_prev  = ratio[i];
                dp_prev  = rhs[i];
            end
            x = clip(rhs[n-1], 16);
            grid[n-1] = x;
            for (int k = n - 2; k >= 0; k--) begin
                x = clip(rhs[k] - rnd14(ratio[k] * x), 16);
                grid[k] = x;
            end
            grid[0]   = longint'(bound_l);
            grid[n-1] = longint'(bound_r);
        endfunction

        function void note_word(logic [15:0] sample, logic last);
            int n;
            if (loaded >= 64)
                loaded = 0;
            grid[loaded] = longint'($signed(sample));
            loaded++;
            if (!last && loaded < 64)
                return;
            n = loaded;
            loaded = 0;
            for (int t = 0; t < steps; t++)
                time_step(n);
            for (int i = 0; i < n; i++) begin
                solved_q.push_back(grid[i][15:0]);
                last_q.push_back(i + 1 == n);
            end
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
            errors++;
        endtask

        task check_word(logic [15:0] sample, logic last);
            logic [15:0] want_s;
            bit          want_l;
            if (solved_q.size() == 0) begin
                report("unexpected word", sample, 16'h0);
                return;
            end
            want_s = solved_q.pop_front();
            want_l = last_q.pop_front();
            if (sample !== want_s)
                report("sample_out", sample, want_s);
            if (last !== want_l)
                report("last_out", {15'b0, last}, {15'b0, want_l});
        endtask

        function int pending();
            return solved_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;    // [15:0] sample_in
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;         // [15:0] sample_out
    logic                  m_tlast;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    cn_scoreboard solver_sb = new();
    int          burst_left = 0;
    int          gap_max = 4;
    int          rx_mode = 0;
    int          words_sent = 0;
    logic [7:0]  rx_cnt = '0;

    crank_nicolson_advection_solver u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                solver_sb.note_word(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                solver_sb.check_word(m_tdata, m_tlast);
        end
    end

    always @(negedge aclk) begin
        rx_cnt <= rx_cnt + 8'd1;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (rx_cnt[3:0] > 4'd5);
        endcase
    end

    task automatic send_word(logic [15:0] d, logic l);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (solver_sb.pending() > 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        solver_sb.set_reg(idx, val);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_sample();
        if ($urandom_range(0, 1))
            return 16'($signed($urandom_range(0, 8192)) - 4096);
        return 16'($urandom());
    endfunction

    // hold last low on a full grid so the node limit ends the load
    task automatic send_grid(int n, bit no_last);
        for (int i = 0; i < n; i++)
            send_word(rand_sample(), (i == n - 1) && !no_last);
        drain();
    endtask

    task automatic send_fixed(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        send_word(a, 1'b0);
        send_word(b, 1'b0);
        send_word(c, 1'b1);
        drain();
    endtask

    initial begin
        int n;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, extremes of the sample range
        send_fixed(16'h8000, 16'h7FFF, 16'h0000);
        write_reg(REG_STEP_COUNT, 16'd0);
        send_fixed(16'hFFFF, 16'h8000, 16'h7FFF);
        write_reg(REG_STEP_COUNT, 16'd3);
        send_word(16'h1234, 1'b1);
        drain();
        write_reg(REG_EXPLICIT_COEF, 16'h7FFF);
        write_reg(REG_IMPLICIT_COEF, 16'h8000);
        write_reg(REG_BOUNDARY_LEFT, 16'h8000);
        write_reg(REG_BOUNDARY_RIGHT, 16'h7FFF);
        send_fixed(16'h7FFF, 16'h8000, 16'h7FFF);
        write_reg(REG_EXPLICIT_COEF, 16'h8000);
        write_reg(REG_IMPLICIT_COEF, 16'h7FFF);
        send_grid(2, 1'b0);
        write_reg(REG_IMPLICIT_COEF, 16'h0000);
        write_reg(REG_EXPLICIT_COEF, 16'h0000);
        write_reg(REG_BOUNDARY_LEFT, 16'h7FFF);
        write_reg(REG_BOUNDARY_RIGHT, 16'h8000);
        send_grid(4, 1'b0);
        write_reg(REG_STEP_COUNT, 16'd1023);
        write_reg(REG_EXPLICIT_COEF, 16'd406);
        write_reg(REG_IMPLICIT_COEF, 16'd406);
        send_fixed(16'h1000, 16'h2000, 16'h0800);
        write_reg(REG_STEP_COUNT, 16'd4);

        while (words_sent < 330) begin
            rx_mode = $urandom_range(0, 2);
            gap_max = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 2) == 0) begin
                write_reg(REG_EXPLICIT_COEF, $urandom_range(0, 4) == 0 ?
                          16'($urandom()) : 16'($signed($urandom_range(0, 8000)) - 4000));
                write_reg(REG_IMPLICIT_COEF, $urandom_range(0, 4) == 0 ?
                          16'($urandom()) : 16'($signed($urandom_range(0, 8000)) - 4000));
                write_reg(REG_BOUNDARY_LEFT, 16'($urandom()));
                write_reg(REG_BOUNDARY_RIGHT, 16'($urandom()));
                write_reg(REG_STEP_COUNT, $urandom_range(0, 9) == 0 ?
                          16'($urandom_range(7, 40)) : 16'($urandom_range(0, 6)));
            end
            if ($urandom_range(0, 14) == 0) begin
                write_reg(REG_STEP_COUNT, 16'($urandom_range(0, 2)));
                send_grid(64, 1'b1);
            end else begin
                n = $urandom_range(1, 12);
                send_grid(n, 1'b0);
            end
        end

        drain();
        if (solver_sb.errors == 0 && solver_sb.pending() == 0)
            $display("tb_crank_nicolson_advection_solver: clean");
        else
            $display("tb_crank_nicolson_advection_solver: errors");
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_crank_nicolson_advection_solver: errors");
        $finish;
    end

endmodule
